// ===== src/b58_pkg.sv =====
// Base58 decoder package: sizes, shared types and the alphabet lookup.
// No dependencies; used by every other file in src.
package b58_pkg;

    localparam int ACC_BYTES    = 25;   // accumulator length, bytes
    localparam int OUT_BYTES    = 20;   // payload bytes per string
    localparam int RADIX        = 58;
    localparam int BYTE_W       = 8;
    localparam int CARRY_W      = 6;    // carry between cells stays below RADIX
    localparam int PROD_W       = BYTE_W + CARRY_W;
    localparam int INDEX_W      = 5;    // width of the byte_index field
    localparam int K_W          = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // Wavefront token handed from cell to cell, least significant end first.
    typedef struct packed {
        logic               vld;
        logic               eot;
        logic [CARRY_W-1:0] carry;
    } t_wave;

    // Control from the sequencer to every cell.
    typedef struct packed {
        logic shift;    // move bytes one cell toward the top
        logic clear;    // zero the accumulator
    } t_cell_ctrl;

    typedef struct packed {
        logic               valid;
        logic [CARRY_W-1:0] digit;
    } t_digit;

    function automatic t_digit digit_of(input logic [BYTE_W-1:0] code);
        t_digit d;
        d.valid = 1'b1;
        d.digit = '0;
        case (code) inside
            [8'd49:8'd57]:   d.digit = CARRY_W'(code - 8'd49);        // '1'..'9'
            [8'd65:8'd72]:   d.digit = CARRY_W'(code - 8'd65 + 8'd9);  // 'A'..'H'
            [8'd74:8'd78]:   d.digit = CARRY_W'(code - 8'd74 + 8'd17); // 'J'..'N'
            [8'd80:8'd90]:   d.digit = CARRY_W'(code - 8'd80 + 8'd22); // 'P'..'Z'
            [8'd97:8'd107]:  d.digit = CARRY_W'(code - 8'd97 + 8'd33); // 'a'..'k'
            [8'd109:8'd122]: d.digit = CARRY_W'(code - 8'd109 + 8'd44);// 'm'..'z'
            default:         d.valid = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// ===== src/b58_if.sv =====
// Valid/ready channel interfaces for character input and byte output.
// Depends on b58_pkg for field widths.
interface b58_in_if;
    logic                       valid;
    logic                       ready;
    logic [b58_pkg::BYTE_W-1:0] char_code;
    logic                       end_of_text;

    modport source (output valid, char_code, end_of_text, input ready);
    modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

interface b58_out_if;
    logic                        valid;
    logic                        ready;
    logic [b58_pkg::BYTE_W-1:0]  hash_byte;
    logic [b58_pkg::INDEX_W-1:0] byte_index;
    logic                        ok;
    logic                        last;

    modport source (output valid, hash_byte, byte_index, ok, last, input ready);
    modport sink   (input valid, hash_byte, byte_index, ok, last, output ready);
endinterface

// ===== src/base58_string_decoder.sv =====
// Base58 string decoder top level: alphabet lookup, cell chain, drain/emit sequencer.
// Depends on b58_pkg, b58_if (b58_in_if, b58_out_if) and b58_cell.
//
//  channel  | dir | beat contents                             | accepted when
//  ---------+-----+-------------------------------------------+---------------------
//  i_char   | in  | char_code, end_of_text                    | valid & ready
//  o_byte   | out | hash_byte, byte_index, ok, last           | valid & ready
//
// Within a string a character is taken every cycle: each one launches a carry
// wave into the least significant cell, and the wave ripples one cell per
// cycle, so successive characters follow each other down the chain.
// On the last character the chain drains until the end-of-string marker leaves
// cell 0; the payload then leaves one byte per cycle unless o_byte stalls (20 beats,
// or one failure beat) by shifting the chain toward the top byte; i_char.ready is low
// meanwhile. A stalled output holds its beat and holds the emit sequence.
// Reset (i_rst_n low, synchronous) zeroes the accumulator and error flag.
module base58_string_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    b58_in_if.sink    i_char,
    b58_out_if.source o_byte
);

    localparam int NC = b58_pkg::ACC_BYTES;

    b58_pkg::t_state     r_state, n_state;
    logic                r_bad;
    logic [b58_pkg::K_W-1:0] r_k;
    logic                r_out_valid;
    logic [b58_pkg::BYTE_W-1:0]  r_hash;
    logic [b58_pkg::INDEX_W-1:0] r_index;
    logic                r_ok;
    logic                r_last;

    b58_pkg::t_digit     w_digit;
    b58_pkg::t_cell_ctrl w_ctrl;
    b58_pkg::t_wave      w_wave [NC+1];
    logic [b58_pkg::BYTE_W-1:0] w_byte [NC+1];
    logic                w_accept;
    logic                w_slot_free;
    logic                w_last_k;
    logic                w_emit;
    logic                w_drained;
    logic                w_overflow;

    assign w_digit     = b58_pkg::digit_of(i_char.char_code);
    assign w_accept    = i_char.valid && i_char.ready;
    assign w_slot_free = !r_out_valid || o_byte.ready;
    assign w_last_k    = (r_k == b58_pkg::K_W'(b58_pkg::OUT_BYTES - 1));

    // wave leaving the top cell: end-of-string marker, or carry out of top byte
    assign w_drained  = w_wave[0].vld && w_wave[0].eot;
    assign w_overflow = w_wave[0].vld && (w_wave[0].carry != '0);

    // An invalid character still launches a zero-digit wave so that its
    // end-of-string marker travels the chain like any other.
    assign w_wave[NC].vld   = w_accept;
    assign w_wave[NC].eot   = i_char.end_of_text;
    assign w_wave[NC].carry = w_digit.valid ? w_digit.digit : '0;
    assign w_byte[NC]       = '0;

    // cell i holds accumulator byte i (0 = most significant)
    for (genvar i = 0; i < NC; i++) begin : g_cell
        b58_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_wave       (w_wave[i+1]),
            .o_wave       (w_wave[i]),
            .i_ctrl       (w_ctrl),
            .i_shift_byte (w_byte[i+1]),
            .o_byte       (w_byte[i])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            b58_pkg::ST_RUN: begin
                if (w_accept && i_char.end_of_text) n_state = b58_pkg::ST_DRAIN;
            end
            b58_pkg::ST_DRAIN: begin
                if (w_drained) n_state = b58_pkg::ST_EMIT;
            end
            b58_pkg::ST_EMIT: begin
                if (w_slot_free && (r_bad || w_last_k)) n_state = b58_pkg::ST_RUN;
            end
            default: n_state = b58_pkg::ST_RUN;
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_char.ready = 1'b0;
        w_emit       = 1'b0;
        case (r_state)
            b58_pkg::ST_RUN:   i_char.ready = 1'b1;
            b58_pkg::ST_DRAIN: i_char.ready = 1'b0;
            b58_pkg::ST_EMIT:  w_emit       = w_slot_free;
            default:           i_char.ready = 1'b0;
        endcase
        w_ctrl.shift = w_emit && !r_bad;
        w_ctrl.clear = w_emit && (r_bad || w_last_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= b58_pkg::ST_RUN;
            r_bad       <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // sticky error: bad character at intake or carry out of the top byte
            if (w_ctrl.clear) begin
                r_bad <= 1'b0;
            end else if ((w_accept && !w_digit.valid) || w_overflow) begin
                r_bad <= 1'b1;
            end
            if (w_ctrl.clear) begin
                r_k <= '0;
            end else if (w_ctrl.shift) begin
                r_k <= r_k + 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_byte.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output beat register; payload byte k is always in cell 1 after k shifts
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_hash  <= r_bad ? '0 : w_byte[1];
            r_index <= r_bad ? '0 : b58_pkg::INDEX_W'(r_k);
            r_ok    <= !r_bad;
            r_last  <= r_bad || w_last_k;
        end
    end

    assign o_byte.valid      = r_out_valid;
    assign o_byte.hash_byte  = r_hash;
    assign o_byte.byte_index = r_index;
    assign o_byte.ok         = r_ok;
    assign o_byte.last       = r_last;

endmodule

// ===== src/b58_cell.sv =====
// One accumulator byte cell: byte = byte*58 + carry_in, carry out to next cell; clear and shift on command.
// Depends on b58_pkg.
module b58_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  b58_pkg::t_wave             i_wave,
    output b58_pkg::t_wave             o_wave,
    input  b58_pkg::t_cell_ctrl        i_ctrl,
    input  logic [b58_pkg::BYTE_W-1:0] i_shift_byte,
    output logic [b58_pkg::BYTE_W-1:0] o_byte
);

    logic [b58_pkg::BYTE_W-1:0] r_byte, n_byte;
    b58_pkg::t_wave             r_wave, n_wave;
    logic [b58_pkg::PROD_W-1:0] w_prod;

    assign w_prod = b58_pkg::PROD_W'(r_byte) * b58_pkg::PROD_W'(b58_pkg::RADIX)
                  + b58_pkg::PROD_W'(i_wave.carry);

    always_comb begin
        n_byte       = r_byte;
        n_wave.vld   = i_wave.vld;
        n_wave.eot   = i_wave.eot;
        n_wave.carry = w_prod[b58_pkg::PROD_W-1:b58_pkg::BYTE_W];
        if (i_ctrl.clear) begin
            n_byte = '0;
        end else if (i_ctrl.shift) begin
            n_byte = i_shift_byte;
        end else if (i_wave.vld) begin
            n_byte = w_prod[b58_pkg::BYTE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
            r_wave <= '0;
        end else begin
            r_byte <= n_byte;
            r_wave <= n_wave;
        end
    end

    assign o_wave = r_wave;
    assign o_byte = r_byte;

endmodule

// ===== src/b58_chk.sv =====
// Port-level checker for the Base58 decoder, bound to the top level.
// Depends on b58_pkg and base58_string_decoder.
module b58_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [b58_pkg::BYTE_W-1:0]   i_hash_byte,
    input logic [b58_pkg::INDEX_W-1:0]  i_byte_index,
    input logic                         i_ok,
    input logic                         i_last
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_hash_byte)
            && $stable(i_byte_index) && $stable(i_ok) && $stable(i_last))
        else $error("output beat changed while stalled");

    // failure beat is a single all-zero beat closing the string
    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ok |-> i_last && (i_hash_byte == '0) && (i_byte_index == '0))
        else $error("malformed failure beat");

    // a good string closes on the final payload position
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_ok && i_last
            |-> i_byte_index == b58_pkg::INDEX_W'(b58_pkg::OUT_BYTES - 1))
        else $error("last beat at wrong byte index");

    // good beats step through the payload in order
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_ok && !i_last ##1 i_out_valid
            |-> i_byte_index == $past(i_byte_index) + 1'b1)
        else $error("byte index did not advance");

    // no beat right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind base58_string_decoder b58_chk u_b58_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_byte.valid),
    .i_out_ready  (o_byte.ready),
    .i_hash_byte  (o_byte.hash_byte),
    .i_byte_index (o_byte.byte_index),
    .i_ok         (o_byte.ok),
    .i_last       (o_byte.last)
);
